// ===== src/sorted_rank_table_macros.svh =====
// Assertion macros shared by the sorted rank table RTL.
`ifndef SORTED_RANK_TABLE_MACROS_SVH
`define SORTED_RANK_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/srt_pkg.sv =====
// Package with sizes, codes, state encoding and helpers of the sorted rank table.
package srt_pkg;

   localparam int TABLE_SLOTS = 256;
   localparam int CAPACITY    = TABLE_SLOTS - 1;
   localparam int CNT_W       = $clog2(TABLE_SLOTS);
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int VAL_W       = 16;
   localparam int RANK_W      = 8;
   localparam logic [RANK_W-1:0] RANK_ABSENT = 8'hFF;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

   // Clamp a count or position to the 8-bit result range.
   function automatic logic [RANK_W-1:0] sat8(input logic [CNT_W-1:0] v);
      logic [CNT_W+RANK_W-1:0] wide;
      wide = {{RANK_W{1'b0}}, v};
      if (wide > (CNT_W+RANK_W)'(255)) begin
         return 8'hFF;
      end else begin
         return wide[RANK_W-1:0];
      end
   endfunction

endpackage

// ===== src/srt_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface srt_req_if import srt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [VAL_W-1:0]   pref_value;

   modport source (output valid, output opcode, output pref_value, input ready);
   modport sink   (input valid, input opcode, input pref_value, output ready);
endinterface

interface srt_rsp_if import srt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANK_W-1:0]  rank;
   logic               was_added;
   logic               overflowed;
   logic [RANK_W-1:0]  entry_count;

   modport source (output valid, output rank, output was_added, output overflowed,
                   output entry_count, input ready);
   modport sink   (input valid, input rank, input was_added, input overflowed,
                   input entry_count, output ready);
endinterface

// ===== src/sorted_rank_table.sv =====
// Sorted rank table: keeps up to 255 distinct 16-bit values in ascending order in a
// single-port-read, single-port-write RAM with a registered read port. Each request
// transaction (clear, insert, lookup) produces exactly one response transaction.
// Clear and the unused opcode go from idle straight to the done state. Insert and
// lookup scan the RAM linearly, one entry per cycle, from the bottom up to the first
// entry not below the key or to the last entry; an insert then moves the larger
// entries up one slot, one read/write per cycle, and writes the new value. A request
// is taken only when the sequencer is idle; a finished response waits in its output
// register, so the next request can be accepted while it is still pending.
// When the table is full, an insert drops the largest entry to make room; a value
// above every entry is not stored. Both cases report an overflow.
module sorted_rank_table
   import srt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   srt_req_if.sink  req_ch,
   srt_rsp_if.source rsp_ch
);

`include "sorted_rank_table_macros.svh"

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [VAL_W-1:0]     key_ff, key_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [RANK_W-1:0]    res_rank_ff, res_rank_in;
   logic                 res_added_ff, res_added_in;
   logic                 res_ovf_ff, res_ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic                 added_ff, added_in;
   logic                 ovf_ff, ovf_in;
   logic [RANK_W-1:0]    entry_count_ff, entry_count_in;

   logic [VAL_W-1:0]     sorted_values_mem [CAPACITY];
   logic [VAL_W-1:0]     rd_data_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [VAL_W-1:0]     wr_data;
   logic                 wr_en;

   logic                 req_take;
   logic                 scan_stop;
   logic [CNT_W-1:0]     pos_next;
   logic                 ins_write;
   logic [CNT_W-1:0]     ins_last;
   logic                 rsp_free;

   assign req_take = req_ch.valid && req_ch.ready;
   assign pos_next = pos_ff + CNT_W'(1);
   assign scan_stop = (rd_data_ff >= key_ff) || (pos_next == count_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // Insert decision once the scan has settled pos_ff and found_ff.
   always_comb begin
      ins_write = 1'b0;
      ins_last  = count_ff;
      if (!found_ff) begin
         if (count_ff < CNT_W'(CAPACITY)) begin
            ins_write = 1'b1;
         end else if (pos_ff < count_ff) begin
            ins_write = 1'b1;
            ins_last  = count_ff - CNT_W'(1);
         end
      end
   end

   // RAM: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sorted_values_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= sorted_values_mem[rd_addr];
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (op_type'(req_ch.opcode) == OP_INSERT ||
                   op_type'(req_ch.opcode) == OP_LOOKUP) begin
                  state_in = (count_ff == '0) ? ST_DECIDE : ST_SEARCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SEARCH: begin
            if (scan_stop) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (op_ff == OP_INSERT && ins_write && ins_last != pos_ff) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (j_ff - CNT_W'(1) == pos_ff) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      pos_in         = pos_ff;
      found_in       = found_ff;
      j_in           = j_ff;
      count_in       = count_ff;
      res_rank_in    = res_rank_ff;
      res_added_in   = res_added_ff;
      res_ovf_in     = res_ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rank_in        = rank_ff;
      added_in       = added_ff;
      ovf_in         = ovf_ff;
      entry_count_in = entry_count_ff;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = j_ff[ADDR_W-1:0];
      wr_data        = rd_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in        = op_type'(req_ch.opcode);
               key_in       = req_ch.pref_value;
               pos_in       = '0;
               found_in     = 1'b0;
               res_rank_in  = '0;
               res_added_in = 1'b0;
               res_ovf_in   = 1'b0;
               if (op_type'(req_ch.opcode) == OP_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_SEARCH: begin
            // rd_data_ff holds the entry at pos_ff
            if (rd_data_ff >= key_ff) begin
               found_in = (rd_data_ff == key_ff);
            end else begin
               pos_in  = pos_next;
               rd_addr = pos_next[ADDR_W-1:0];
            end
         end
         ST_DECIDE: begin
            if (op_ff == OP_LOOKUP) begin
               res_rank_in = found_ff ? sat8(pos_ff) : RANK_ABSENT;
            end else if (!found_ff) begin
               if (count_ff < CNT_W'(CAPACITY)) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  res_ovf_in = 1'b1;
               end
               res_added_in = ins_write;
               j_in         = ins_last;
               if (ins_write) begin
                  if (ins_last == pos_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = pos_ff[ADDR_W-1:0];
                     wr_data = key_ff;
                  end else begin
                     rd_addr = ADDR_W'(ins_last - CNT_W'(1));
                  end
               end
            end
         end
         ST_SHIFT: begin
            // move entry j-1 into slot j, fetch j-2 for the next cycle
            wr_en   = 1'b1;
            wr_addr = j_ff[ADDR_W-1:0];
            wr_data = rd_data_ff;
            j_in    = j_ff - CNT_W'(1);
            rd_addr = ADDR_W'(j_ff - CNT_W'(2));
         end
         ST_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[ADDR_W-1:0];
            wr_data = key_ff;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rank_in        = res_rank_ff;
               added_in       = res_added_ff;
               ovf_in         = res_ovf_ff;
               entry_count_in = sat8(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      pos_ff         <= pos_in;
      found_ff       <= found_in;
      j_ff           <= j_in;
      res_rank_ff    <= res_rank_in;
      res_added_ff   <= res_added_in;
      res_ovf_ff     <= res_ovf_in;
      rank_ff        <= rank_in;
      added_ff       <= added_in;
      ovf_ff         <= ovf_in;
      entry_count_ff <= entry_count_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.rank        = rank_ff;
   assign rsp_ch.was_added   = added_ff;
   assign rsp_ch.overflowed  = ovf_ff;
   assign rsp_ch.entry_count = entry_count_ff;

   `SRT_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "stored count exceeds table capacity")
   `SRT_ASSERT_NEXT(a_take_busy, clock, reset, req_take, state_ff != ST_IDLE,
      "sequencer stayed idle after taking a transaction")
   `SRT_ASSERT_NOW(a_shift_above, clock, reset, state_ff == ST_SHIFT,
      j_ff > pos_ff && j_ff < count_ff, "shift slot outside the moved range")
   `SRT_ASSERT_NOW(a_added_nonempty, clock, reset, rsp_valid_ff && added_ff,
      entry_count_ff != '0, "value reported added into an empty table")

endmodule
